FILE: hw/rtl/lfdvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfdvc_pkg
// Types, codes and constants of the labelled face drop and vertex compactor.
// ----------------------------------------------------------------------------
package lfdvc_pkg;

  // field widths
  localparam int unsigned VIDX_W  = 16;
  localparam int unsigned NIDX_W  = 17;
  localparam int unsigned CNT_W   = 18;
  localparam int unsigned LABEL_W = 16;
  localparam int unsigned EPOCH_W = 8;

  // remap memory
  localparam int unsigned VERTS       = 65536;
  localparam int unsigned DROP_SLOTS  = 6;
  localparam logic [2:0]  DROP_SLOTS_CODE = 3'd6;

  // result queue
  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned FIFO_AW    = 4;
  localparam int unsigned FIFO_CW    = 5;

  localparam logic [CNT_W-1:0]   CNT_MAX     = '1;
  localparam logic [NIDX_W-1:0]  VCOUNT_RST  = 17'h10000;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  // register indexes
  localparam logic [2:0] REG_DROP_LABEL_0 = 3'd0;
  localparam logic [2:0] REG_DROP_LABEL_1 = 3'd1;
  localparam logic [2:0] REG_DROP_LABEL_2 = 3'd2;
  localparam logic [2:0] REG_DROP_LABEL_3 = 3'd3;
  localparam logic [2:0] REG_DROP_LABEL_4 = 3'd4;
  localparam logic [2:0] REG_DROP_LABEL_5 = 3'd5;
  localparam logic [2:0] REG_DROP_COUNT   = 3'd6;
  localparam logic [2:0] REG_VERTEX_COUNT = 3'd7;

  // corner steps
  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;

  typedef enum logic [1:0] {
    KIND_COPY    = 2'd0,
    KIND_FACE    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INDEX_ERROR = 2'd1,
    ST_NONE_REMOVED = 2'd2,
    ST_ALL_REMOVED = 2'd3
  } status_e;

  // one remap memory word: mesh epoch tag and new index
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [VIDX_W-1:0]  idx;
  } entry_t;

  // step handed from the issue stage to the evaluate stage
  typedef struct packed {
    logic              v;
    logic              is_corner;
    logic [1:0]        cidx;
    logic              last;
    logic              fin;
    logic [VIDX_W-1:0] corner;
    logic [CNT_W-1:0]  removed;
    status_e           status;
  } tok_t;

  // last memory write, for read-during-write bypass
  typedef struct packed {
    logic              v;
    logic [VIDX_W-1:0] addr;
    logic [VIDX_W-1:0] idx;
  } fwd_t;

  // one queued result item
  typedef struct packed {
    kind_e             kind;
    logic [VIDX_W-1:0] src;
    logic [VIDX_W-1:0] tgt;
    logic [VIDX_W-1:0] na;
    logic [VIDX_W-1:0] nb;
    logic [VIDX_W-1:0] nc;
    logic [CNT_W-1:0]  removed;
    logic [NIDX_W-1:0] kept;
    status_e           status;
    logic              eob;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/labelled_face_drop_vertex_compactor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// labelled_face_drop_vertex_compactor_top
// Drops labelled triangles and remaps kept vertices to dense new indices.
//
//   channel   direction  handshake                 payload
//   cfg       in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//   in        in         in_valid_i / in_stall_o   face_label_i, corner_*_i, final_face_i
//   out       out        out_valid_o / out_stall_i kind_o ... end_of_burst_o
//
// A kept triangle issues one step per corner read of the remap memory
// (one read and one write port); a dropped or rejected triangle issues one.
// The issue stage reads a corner, the evaluate stage tags or assigns it in the
// cycle after and queues results in a 16-entry queue; the queue sets the rate
// when the output is stalled or a triangle yields more results than cycles.
// After reset, and after every 255th mesh, a clearing pass runs through all
// 65536 entries of the remap memory while no triangle is processed.
// ----------------------------------------------------------------------------
module labelled_face_drop_vertex_compactor_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [2:0]                           cfg_idx_i,
  input  logic [lfdvc_pkg::NIDX_W-1:0]         cfg_wdata_i,
  // triangle items
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [lfdvc_pkg::LABEL_W-1:0] face_label_i,
  input  logic [lfdvc_pkg::VIDX_W-1:0]         corner_a_i,
  input  logic [lfdvc_pkg::VIDX_W-1:0]         corner_b_i,
  input  logic [lfdvc_pkg::VIDX_W-1:0]         corner_c_i,
  input  logic                                 final_face_i,
  // result items
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           kind_o,
  output logic [lfdvc_pkg::VIDX_W-1:0]         source_vertex_o,
  output logic [lfdvc_pkg::VIDX_W-1:0]         target_vertex_o,
  output logic [lfdvc_pkg::VIDX_W-1:0]         new_a_o,
  output logic [lfdvc_pkg::VIDX_W-1:0]         new_b_o,
  output logic [lfdvc_pkg::VIDX_W-1:0]         new_c_o,
  output logic [lfdvc_pkg::CNT_W-1:0]          removed_faces_o,
  output logic [lfdvc_pkg::NIDX_W-1:0]         kept_vertices_o,
  output logic [1:0]                           status_o,
  output logic                                 end_of_burst_o
);
  import lfdvc_pkg::*;

  // configuration registers
  logic [LABEL_W-1:0] drop_label_q [DROP_SLOTS];
  logic [2:0]         drop_cnt_q;
  logic [NIDX_W-1:0]  vcount_q;

  // held input item
  logic               itm_v_q;
  logic [LABEL_W-1:0] itm_label_q;
  logic [VIDX_W-1:0]  itm_corner_q [3];
  logic               itm_fin_q;
  logic [1:0]         step_q, step_d;

  // mesh counters at issue
  logic [CNT_W-1:0]   face_q, removed_q;
  logic               err_q;

  // evaluate stage
  tok_t               e_q, tok_d;
  fwd_t               fwd_q, fwd_d;
  logic [NIDX_W-1:0]  nidx_q, nidx_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [VIDX_W-1:0]  m0_q, m1_q;

  // remap memory and clearing pass
  entry_t             mem_q [VERTS];
  entry_t             rd_q;
  logic               clr_q, clr_d;
  logic [VIDX_W-1:0]  clr_addr_q;

  // result queue
  res_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] cnt_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DROP_SLOTS; i++) drop_label_q[i] <= '0;
      drop_cnt_q <= '0;
      vcount_q   <= VCOUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DROP_LABEL_0, REG_DROP_LABEL_1, REG_DROP_LABEL_2,
        REG_DROP_LABEL_3, REG_DROP_LABEL_4, REG_DROP_LABEL_5: begin
          drop_label_q[cfg_idx_i] <= cfg_wdata_i[LABEL_W-1:0];
        end
        REG_DROP_COUNT:   drop_cnt_q <= cfg_wdata_i[2:0];
        REG_VERTEX_COUNT: vcount_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- issue

  logic [2:0]         drop_n;
  logic               dropped, bad, kept, item_last, wrap_block, room, issue;
  logic [CNT_W-1:0]   face_n, removed_n;
  logic               err_n;
  status_e            status_n;

  // label and range checks on the held item
  always_comb begin
    drop_n  = (drop_cnt_q > DROP_SLOTS_CODE) ? DROP_SLOTS_CODE : drop_cnt_q;
    dropped = 1'b0;
    for (int i = 0; i < DROP_SLOTS; i++) begin
      if ((3'(i) < drop_n) && (drop_label_q[i] == itm_label_q)) dropped = 1'b1;
    end
    bad = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if ({1'b0, itm_corner_q[j]} >= vcount_q) bad = 1'b1;
    end
  end

  assign kept      = !err_q && !dropped && !bad;
  assign item_last = !kept || (step_q == CORNER_C);

  // no new step while the evaluate stage closes a mesh that starts a clearing pass
  assign wrap_block = e_q.v && e_q.last && e_q.fin && (epoch_q == EPOCH_LAST);
  // room for the results of the step in evaluate and of this step
  assign room       = cnt_q <= FIFO_CW'(FIFO_DEPTH - 6);
  assign issue      = itm_v_q && !clr_q && !wrap_block && room;
  assign in_stall_o = itm_v_q && !(issue && item_last);

  // counters after this item
  always_comb begin
    if (err_q) begin
      face_n    = face_q;
      removed_n = removed_q;
      err_n     = 1'b1;
    end else begin
      face_n    = sat_inc(face_q);
      removed_n = dropped ? sat_inc(removed_q) : removed_q;
      err_n     = !dropped && bad;
    end
    if (err_n)                       status_n = ST_INDEX_ERROR;
    else if (removed_n == face_n)    status_n = ST_ALL_REMOVED;
    else if (removed_n == '0)        status_n = ST_NONE_REMOVED;
    else                             status_n = ST_OK;
  end

  // step handed on to evaluate
  always_comb begin
    tok_d.v         = issue;
    tok_d.is_corner = kept;
    tok_d.cidx      = step_q;
    tok_d.last      = item_last;
    tok_d.fin       = itm_fin_q;
    tok_d.corner    = itm_corner_q[step_q];
    tok_d.removed   = removed_n;
    tok_d.status    = status_n;
    step_d          = step_q;
    if (issue) step_d = item_last ? CORNER_A : step_q + 2'd1;
  end

  // input holding register and issue-side state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      itm_v_q   <= 1'b0;
      step_q    <= CORNER_A;
      face_q    <= '0;
      removed_q <= '0;
      err_q     <= 1'b0;
      e_q       <= '0;
    end else begin
      step_q <= step_d;
      e_q    <= tok_d;
      if (in_valid_i && !in_stall_o) begin
        itm_v_q <= 1'b1;
      end else if (issue && item_last) begin
        itm_v_q <= 1'b0;
      end
      if (issue && item_last) begin
        if (itm_fin_q) begin
          face_q    <= '0;
          removed_q <= '0;
          err_q     <= 1'b0;
        end else begin
          face_q    <= face_n;
          removed_q <= removed_n;
          err_q     <= err_n;
        end
      end
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      itm_label_q     <= face_label_i;
      itm_corner_q[0] <= corner_a_i;
      itm_corner_q[1] <= corner_b_i;
      itm_corner_q[2] <= corner_c_i;
      itm_fin_q       <= final_face_i;
    end
  end

  // ------------------------------------------------------------- evaluate

  logic              fwd_hit, hit, e_new, e_close;
  logic [VIDX_W-1:0] hit_idx, mapped;
  logic              p_copy, p_face, p_sum;
  res_t              copy_r, face_r, sum_r;

  // a corner is known if the write of the cycle before hits it or its tag is current
  assign fwd_hit = fwd_q.v && (fwd_q.addr == e_q.corner);
  assign hit     = fwd_hit || (rd_q.epoch == epoch_q);
  assign hit_idx = fwd_hit ? fwd_q.idx : rd_q.idx;
  assign mapped  = hit ? hit_idx : nidx_q[VIDX_W-1:0];
  assign e_new   = e_q.v && e_q.is_corner && !hit;
  assign e_close = e_q.v && e_q.last && e_q.fin;

  always_comb begin
    nidx_d    = nidx_q + NIDX_W'(e_new);
    fwd_d.v    = e_new && !e_close;
    fwd_d.addr = e_q.corner;
    fwd_d.idx  = nidx_q[VIDX_W-1:0];
    epoch_d    = epoch_q;
    clr_d      = clr_q;
    if (e_close) begin
      nidx_d = '0;
      if (epoch_q == EPOCH_LAST) clr_d = 1'b1;
      else                       epoch_d = epoch_q + 1'b1;
    end
    if (clr_q && (clr_addr_q == '1)) begin
      clr_d   = 1'b0;
      epoch_d = EPOCH_FIRST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nidx_q     <= '0;
      fwd_q      <= '0;
      epoch_q    <= EPOCH_FIRST;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      nidx_q  <= nidx_d;
      fwd_q   <= fwd_d;
      epoch_q <= epoch_d;
      clr_q   <= clr_d;
      if (clr_q) clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // mapped corners kept for the face result
  always_ff @(posedge clk_i) begin
    if (e_q.v && e_q.is_corner && (e_q.cidx == CORNER_A)) m0_q <= mapped;
    if (e_q.v && e_q.is_corner && (e_q.cidx == CORNER_B)) m1_q <= mapped;
  end

  // remap memory: one write port, one registered read port
  logic              mem_we;
  logic [VIDX_W-1:0] mem_wa;
  entry_t            mem_wd;

  assign mem_we = clr_q || e_new;
  assign mem_wa = clr_q ? clr_addr_q : e_q.corner;
  assign mem_wd = clr_q ? '0 : entry_t'{epoch: epoch_q, idx: nidx_q[VIDX_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[itm_corner_q[step_q]];
  end

  // --------------------------------------------------------------- results

  assign p_copy = e_new;
  assign p_face = e_q.v && e_q.is_corner && (e_q.cidx == CORNER_C);
  assign p_sum  = e_close;

  always_comb begin
    copy_r      = '0;
    copy_r.kind = KIND_COPY;
    copy_r.src  = e_q.corner;
    copy_r.tgt  = nidx_q[VIDX_W-1:0];

    face_r      = '0;
    face_r.kind = KIND_FACE;
    face_r.na   = m0_q;
    face_r.nb   = m1_q;
    face_r.nc   = mapped;
    face_r.eob  = !p_sum;

    sum_r         = '0;
    sum_r.kind    = KIND_SUMMARY;
    sum_r.removed = e_q.removed;
    sum_r.kept    = nidx_q + NIDX_W'(e_new);
    sum_r.status  = e_q.status;
    sum_r.eob     = 1'b1;
  end

  logic [FIFO_AW-1:0] wa_face, wa_sum;
  logic [1:0]         n_push;
  logic               pop;

  assign wa_face = wr_ptr_q + FIFO_AW'(p_copy);
  assign wa_sum  = wa_face + FIFO_AW'(p_face);
  assign n_push  = 2'(p_copy) + 2'(p_face) + 2'(p_sum);
  assign pop     = out_valid_o && !out_stall_i;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (p_copy) fifo_q[wr_ptr_q] <= copy_r;
    if (p_face) fifo_q[wa_face]  <= face_r;
    if (p_sum)  fifo_q[wa_sum]   <= sum_r;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_AW'(n_push);
      rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
      cnt_q    <= cnt_q + FIFO_CW'(n_push) - FIFO_CW'(pop);
    end
  end

  // output side
  res_t out_r;
  assign out_r           = fifo_q[rd_ptr_q];
  assign out_valid_o     = cnt_q != '0;
  assign kind_o          = out_r.kind;
  assign source_vertex_o = out_r.src;
  assign target_vertex_o = out_r.tgt;
  assign new_a_o         = out_r.na;
  assign new_b_o         = out_r.nb;
  assign new_c_o         = out_r.nc;
  assign removed_faces_o = out_r.removed;
  assign kept_vertices_o = out_r.kept;
  assign status_o        = out_r.status;
  assign end_of_burst_o  = out_r.eob;

  // ------------------------------------------------------------ assertions

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !e_q.v)
    else $error("corner evaluated during clearing pass");

  a_mesh_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_close |=> (nidx_q == '0) && !fwd_q.v)
    else $error("mesh state not cleared after summary");

endmodule
`default_nettype wire

FILE: tb/sv/lfdvc_mesh_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfdvc_mesh_checker
// Watches the triangle, result and register channels of the face drop and
// vertex compactor, predicts every result item from its own copy of the
// drop labels, vertex bound and remap table, and compares each accepted
// result item with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module lfdvc_mesh_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // register writes
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [lfdvc_pkg::NIDX_W-1:0] cfg_wdata_i,
  // triangle items
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [lfdvc_pkg::LABEL_W-1:0] face_label_i,
  input  logic [lfdvc_pkg::VIDX_W-1:0] corner_a_i,
  input  logic [lfdvc_pkg::VIDX_W-1:0] corner_b_i,
  input  logic [lfdvc_pkg::VIDX_W-1:0] corner_c_i,
  input  logic                         final_face_i,
  // result items
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [1:0]                   kind_i,
  input  logic [lfdvc_pkg::VIDX_W-1:0] source_vertex_i,
  input  logic [lfdvc_pkg::VIDX_W-1:0] target_vertex_i,
  input  logic [lfdvc_pkg::VIDX_W-1:0] new_a_i,
  input  logic [lfdvc_pkg::VIDX_W-1:0] new_b_i,
  input  logic [lfdvc_pkg::VIDX_W-1:0] new_c_i,
  input  logic [lfdvc_pkg::CNT_W-1:0]  removed_faces_i,
  input  logic [lfdvc_pkg::NIDX_W-1:0] kept_vertices_i,
  input  logic [1:0]                   status_i,
  input  logic                         end_of_burst_i,
  // to the testbench top
  output int                           mismatch_count_o,
  output int                           results_left_o,
  output int                           results_seen_o
);
  import lfdvc_pkg::*;

  localparam int unsigned SHOWN_MAX = 10;

  // register copies
  logic [LABEL_W-1:0] drop_lbl [DROP_SLOTS];
  logic [2:0]         drop_used;
  logic [NIDX_W-1:0]  vert_limit;

  // per-mesh compaction state
  logic [NIDX_W-1:0]  new_index_of [VERTS];
  bit                 assigned [VERTS];
  logic [VIDX_W-1:0]  touched_q [$];
  logic [NIDX_W-1:0]  next_index;
  logic [CNT_W-1:0]   removed_cnt;
  logic [CNT_W-1:0]   face_cnt;
  logic               index_bad;

  // predicted result items, oldest first
  res_t               mesh_results_q [$];
  int                 mismatches = 0;
  int                 seen = 0;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // a count above the number of slots uses every slot
  function automatic bit label_dropped(input logic [LABEL_W-1:0] lbl);
    int n;
    bit hit;
    n = (drop_used > DROP_SLOTS_CODE) ? DROP_SLOTS : int'(drop_used);
    hit = 1'b0;
    for (int s = 0; s < n; s++) begin
      if (drop_lbl[s] == lbl) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic string describe_result(input res_t r);
    return $sformatf("kind %0d copy %0d->%0d face %0d/%0d/%0d removed %0d kept %0d status %0d eob %0d",
                     r.kind, r.src, r.tgt, r.na, r.nb, r.nc, r.removed, r.kept, r.status, r.eob);
  endfunction

  // back to an empty mesh, only the touched entries need clearing
  task automatic clear_mesh_state();
    while (touched_q.size() > 0) assigned[touched_q.pop_back()] = 1'b0;
    next_index  = '0;
    removed_cnt = '0;
    face_cnt    = '0;
    index_bad   = 1'b0;
  endtask

  // results caused by one triangle, appended in order
  task automatic compact_triangle(input logic [LABEL_W-1:0] lbl,
                                  input logic [VIDX_W-1:0] ca,
                                  input logic [VIDX_W-1:0] cb,
                                  input logic [VIDX_W-1:0] cc,
                                  input logic fin);
    logic [VIDX_W-1:0] corner [3];
    logic [VIDX_W-1:0] mapped [3];
    res_t              burst [5];
    int                n;
    bit                bad;
    status_e           st;
    corner[0] = ca;
    corner[1] = cb;
    corner[2] = cc;
    n = 0;
    if (!index_bad) begin
      face_cnt = bump(face_cnt);
      if (label_dropped(lbl)) begin
        removed_cnt = bump(removed_cnt);
      end else begin
        bad = 1'b0;
        for (int i = 0; i < 3; i++) begin
          if ({1'b0, corner[i]} >= vert_limit) bad = 1'b1;
        end
        if (bad) begin
          index_bad = 1'b1;
        end else begin
          // corners in order, so a repeated vertex is assigned once
          for (int i = 0; i < 3; i++) begin
            if (!assigned[corner[i]]) begin
              assigned[corner[i]]     = 1'b1;
              new_index_of[corner[i]] = next_index;
              touched_q.push_front(corner[i]);
              next_index              = next_index + 1'b1;
              burst[n]                = '0;
              burst[n].kind           = KIND_COPY;
              burst[n].src            = corner[i];
              burst[n].tgt            = new_index_of[corner[i]][VIDX_W-1:0];
              n++;
            end
            mapped[i] = new_index_of[corner[i]][VIDX_W-1:0];
          end
          burst[n]      = '0;
          burst[n].kind = KIND_FACE;
          burst[n].na   = mapped[0];
          burst[n].nb   = mapped[1];
          burst[n].nc   = mapped[2];
          n++;
        end
      end
    end
    if (fin) begin
      if (index_bad)                  st = ST_INDEX_ERROR;
      else if (removed_cnt == face_cnt) st = ST_ALL_REMOVED;
      else if (removed_cnt == '0)     st = ST_NONE_REMOVED;
      else                            st = ST_OK;
      burst[n]         = '0;
      burst[n].kind    = KIND_SUMMARY;
      burst[n].removed = removed_cnt;
      burst[n].kept    = next_index;
      burst[n].status  = st;
      n++;
      clear_mesh_state();
    end
    if (n > 0) burst[n-1].eob = 1'b1;
    for (int i = 0; i < n; i++) mesh_results_q.insert(mesh_results_q.size(), burst[i]);
  endtask

  // register writes, triangles in, results out
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      for (int s = 0; s < DROP_SLOTS; s++) drop_lbl[s] = '0;
      drop_used  = '0;
      vert_limit = VCOUNT_RST;
      clear_mesh_state();
      mesh_results_q.delete();
      mismatch_count_o <= mismatches;
      results_left_o   <= 0;
      results_seen_o   <= seen;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DROP_LABEL_0, REG_DROP_LABEL_1, REG_DROP_LABEL_2,
          REG_DROP_LABEL_3, REG_DROP_LABEL_4, REG_DROP_LABEL_5: begin
            drop_lbl[cfg_idx_i] = cfg_wdata_i[LABEL_W-1:0];
          end
          REG_DROP_COUNT: begin
            drop_used = cfg_wdata_i[2:0];
          end
          REG_VERTEX_COUNT: begin
            vert_limit = cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        compact_triangle(face_label_i, corner_a_i, corner_b_i, corner_c_i, final_face_i);
      end

      if (out_valid_i && !out_stall_i) begin
        seen++;
        got.kind    = kind_e'(kind_i);
        got.src     = source_vertex_i;
        got.tgt     = target_vertex_i;
        got.na      = new_a_i;
        got.nb      = new_b_i;
        got.nc      = new_c_i;
        got.removed = removed_faces_i;
        got.kept    = kept_vertices_i;
        got.status  = status_e'(status_i);
        got.eob     = end_of_burst_i;
        if (mesh_results_q.size() == 0) begin
          if (mismatches < SHOWN_MAX) begin
            $display("unexpected result item %0d: %s", seen, describe_result(got));
          end
          mismatches++;
        end else begin
          want = mesh_results_q.pop_front();
          if (got !== want) begin
            if (mismatches < SHOWN_MAX) begin
              $display("result item %0d differs", seen);
              $display("  wanted %s", describe_result(want));
              $display("  got    %s", describe_result(got));
            end
            mismatches++;
          end
        end
      end

      mismatch_count_o <= mismatches;
      results_left_o   <= mesh_results_q.size();
      results_seen_o   <= seen;
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Stimulus for the labelled face drop and vertex compactor: a directed set of
// meshes for label extremes, repeated corners, error and summary cases, then
// random meshes under changing drop labels and vertex bounds, with sender
// gaps and receiver stalls in several regimes. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb;
  import lfdvc_pkg::*;

  localparam int unsigned HALF_PERIOD   = 6;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned RANDOM_ITEMS  = 200;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned MAX_GAP       = 12;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SMALL_MESH    = 64;

  typedef enum int {
    PH_STEADY,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH_IDLE
  } phase_e;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [2:0]          cfg_idx_i    = '0;
  logic [NIDX_W-1:0]   cfg_wdata_i  = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [LABEL_W-1:0]  face_label_i = '0;
  logic [VIDX_W-1:0]   corner_a_i   = '0;
  logic [VIDX_W-1:0]   corner_b_i   = '0;
  logic [VIDX_W-1:0]   corner_c_i   = '0;
  logic                final_face_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [1:0]          kind_o;
  logic [VIDX_W-1:0]   source_vertex_o;
  logic [VIDX_W-1:0]   target_vertex_o;
  logic [VIDX_W-1:0]   new_a_o;
  logic [VIDX_W-1:0]   new_b_o;
  logic [VIDX_W-1:0]   new_c_o;
  logic [CNT_W-1:0]    removed_faces_o;
  logic [NIDX_W-1:0]   kept_vertices_o;
  logic [1:0]          status_o;
  logic                end_of_burst_o;

  int                  mismatch_count;
  int                  results_left;
  int                  results_seen;

  // register settings of the current mesh
  logic [LABEL_W-1:0]  lbl_cfg [DROP_SLOTS];
  logic [2:0]          lbl_cnt_cfg;
  logic [NIDX_W-1:0]   vcount_cfg;

  int                  send_idle_pct = 0;
  int                  stall_pct     = 0;
  int                  faces_sent    = 0;
  int                  meshes_sent   = 0;

  labelled_face_drop_vertex_compactor_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .face_label_i    (face_label_i),
    .corner_a_i      (corner_a_i),
    .corner_b_i      (corner_b_i),
    .corner_c_i      (corner_c_i),
    .final_face_i    (final_face_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .source_vertex_o (source_vertex_o),
    .target_vertex_o (target_vertex_o),
    .new_a_o         (new_a_o),
    .new_b_o         (new_b_o),
    .new_c_o         (new_c_o),
    .removed_faces_o (removed_faces_o),
    .kept_vertices_o (kept_vertices_o),
    .status_o        (status_o),
    .end_of_burst_o  (end_of_burst_o)
  );

  lfdvc_mesh_checker mesh_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .face_label_i     (face_label_i),
    .corner_a_i       (corner_a_i),
    .corner_b_i       (corner_b_i),
    .corner_c_i       (corner_c_i),
    .final_face_i     (final_face_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_i           (kind_o),
    .source_vertex_i  (source_vertex_o),
    .target_vertex_i  (target_vertex_o),
    .new_a_i          (new_a_o),
    .new_b_i          (new_b_o),
    .new_c_i          (new_c_o),
    .removed_faces_i  (removed_faces_o),
    .kept_vertices_i  (kept_vertices_o),
    .status_i         (status_o),
    .end_of_burst_i   (end_of_burst_o),
    .mismatch_count_o (mismatch_count),
    .results_left_o   (results_left),
    .results_seen_o   (results_seen)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // watchdog
  initial begin : watchdog
    for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d result items still pending",
             CYCLE_LIMIT, results_left);
    $display("Some tests failed");
    $finish;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [NIDX_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // every register, enable dropped only after the last one
  task automatic program_regs();
    for (int s = 0; s < DROP_SLOTS; s++) begin
      write_reg(REG_DROP_LABEL_0 + 3'(s), {1'b0, lbl_cfg[s]});
    end
    write_reg(REG_DROP_COUNT, NIDX_W'(lbl_cnt_cfg));
    write_reg(REG_VERTEX_COUNT, vcount_cfg);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_face(input logic [LABEL_W-1:0] lbl,
                           input logic [VIDX_W-1:0] a,
                           input logic [VIDX_W-1:0] b,
                           input logic [VIDX_W-1:0] c,
                           input logic fin);
    int gap;
    in_valid_i   <= 1'b1;
    face_label_i <= lbl;
    corner_a_i   <= a;
    corner_b_i   <= b;
    corner_c_i   <= c;
    final_face_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    faces_sent++;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold the sender until every predicted result item has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_left != 0) @(posedge clk_i);
  endtask

  // idle and past the pipeline, safe for register writes
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [LABEL_W-1:0] pick_label_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4)       return LABEL_W'($urandom());
    else if (sel == 4) return 16'h8000;
    else if (sel == 5) return 16'h7fff;
    else if (sel == 6) return 16'hffff;
    else               return LABEL_W'($urandom_range(0, 8) - 4);
  endfunction

  function automatic bit drops_label(input logic [LABEL_W-1:0] lbl);
    bit hit;
    hit = 1'b0;
    for (int s = 0; s < DROP_SLOTS; s++) begin
      if (s < int'(lbl_cnt_cfg) && lbl_cfg[s] == lbl) hit = 1'b1;
    end
    return hit;
  endfunction

  // mostly a window around the mesh base so vertices repeat
  function automatic logic [VIDX_W-1:0] pick_corner(input logic [NIDX_W-1:0] vc,
                                                    input int base);
    if (vc > SMALL_MESH && $urandom_range(0, 2) == 0) begin
      return VIDX_W'($urandom_range(0, int'(vc) - 1));
    end
    return VIDX_W'((base + int'($urandom_range(0, 11))) % int'(vc));
  endfunction

  task automatic random_config();
    int sel;
    for (int s = 0; s < DROP_SLOTS; s++) lbl_cfg[s] = pick_label_value();
    lbl_cnt_cfg = 3'($urandom_range(0, DROP_SLOTS));
    sel = $urandom_range(0, 99);
    if (sel < 12)      vcount_cfg = VCOUNT_RST;
    else if (sel < 20) vcount_cfg = 17'd1;
    else if (sel < 25) vcount_cfg = 17'(VERTS - 1);
    else               vcount_cfg = 17'($urandom_range(2, 48));
  endtask

  initial begin : stimulus
    logic [LABEL_W-1:0] lbl;
    logic [VIDX_W-1:0]  a;
    logic [VIDX_W-1:0]  b;
    logic [VIDX_W-1:0]  c;
    logic [VIDX_W-1:0]  wild;
    int                 random_items;
    int                 mesh_len;
    int                 base;
    bit                 broken;
    bit                 breaks_now;
    bit                 paused_once;
    phase_e             ph;

    random_items = 0;
    paused_once  = 1'b0;
    lbl_cfg[0]   = 16'h8000;
    lbl_cfg[1]   = 16'h7fff;
    lbl_cfg[2]   = 16'h0000;
    lbl_cfg[3]   = 16'hffff;
    lbl_cfg[4]   = 16'd5;
    lbl_cfg[5]   = 16'd7;
    lbl_cnt_cfg  = 3'd6;
    vcount_cfg   = VCOUNT_RST;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extreme labels in all six slots, repeated corners, five-item burst
    program_regs();
    meshes_sent++;
    send_face(16'd3, 16'd0, 16'hffff, 16'd0, 1'b0);
    send_face(16'h8000, 16'd1, 16'd2, 16'd3, 1'b0);
    send_face(16'h7fff, 16'd4, 16'd5, 16'd6, 1'b0);
    send_face(16'd7, 16'd9, 16'd9, 16'd9, 1'b0);
    send_face(16'd100, 16'hffff, 16'd0, 16'hffff, 1'b0);
    send_face(16'hfffe, 16'd1, 16'd2, 16'd3, 1'b1);

    // every triangle removed, then nothing removed
    meshes_sent++;
    send_face(16'hffff, 16'haaaa, 16'h5555, 16'h0f0f, 1'b1);
    meshes_sent++;
    send_face(16'h1234, 16'd10, 16'd10, 16'd10, 1'b1);

    // no active labels, single vertex; a bad corner poisons the mesh
    settle();
    lbl_cnt_cfg = 3'd0;
    vcount_cfg  = 17'd1;
    program_regs();
    meshes_sent++;
    send_face(16'h0000, 16'd0, 16'd0, 16'd0, 1'b0);
    send_face(16'h0000, 16'd0, 16'd1, 16'd0, 1'b0);
    send_face(16'h0000, 16'd0, 16'd0, 16'd0, 1'b0);
    send_face(16'h7fff, 16'd0, 16'd0, 16'd0, 1'b1);

    // label count beyond the slots, vertex bound of zero
    settle();
    lbl_cnt_cfg = 3'd7;
    vcount_cfg  = 17'd0;
    program_regs();
    meshes_sent++;
    send_face(16'd7, 16'hffff, 16'h0000, 16'h8000, 1'b0);
    send_face(16'd9, 16'd0, 16'd0, 16'd0, 1'b0);
    send_face(16'd9, 16'd0, 16'd0, 16'd0, 1'b1);

    // one active label, bound one short of the full range
    settle();
    lbl_cnt_cfg = 3'd1;
    vcount_cfg  = 17'(VERTS - 1);
    program_regs();
    meshes_sent++;
    send_face(16'h7fff, 16'hfffe, 16'd0, 16'd1, 1'b0);
    send_face(16'h8000, 16'd2, 16'd3, 16'd4, 1'b1);
    meshes_sent++;
    send_face(16'd5, 16'd3, 16'hffff, 16'd3, 1'b1);

    // random meshes, idling regime moves on with progress
    while (random_items < RANDOM_ITEMS) begin
      ph = phase_e'((random_items * 4) / RANDOM_ITEMS);
      case (ph)
        PH_STEADY: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        PH_SENDER_IDLE: begin
          send_idle_pct = 51;
          stall_pct     = 0;
        end
        PH_RECEIVER_STALL: begin
          send_idle_pct = 0;
          stall_pct     = 51;
        end
        default: begin
          send_idle_pct = 23;
          stall_pct     = 23;
        end
      endcase
      settle();
      random_config();
      program_regs();
      meshes_sent++;
      mesh_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
      base     = (vcount_cfg > SMALL_MESH) ? $urandom_range(0, int'(vcount_cfg) - 1) : 0;
      broken   = 1'b0;
      for (int f = 0; f < mesh_len; f++) begin
        if (f > 0 && ((!paused_once && f == 2) || $urandom_range(0, 39) == 0)) begin
          drain();
          paused_once = 1'b1;
        end
        if (lbl_cnt_cfg != 3'd0 && $urandom_range(0, 99) < 35) begin
          lbl = lbl_cfg[$urandom_range(0, int'(lbl_cnt_cfg) - 1)];
        end else begin
          lbl = pick_label_value();
        end
        a = pick_corner(vcount_cfg, base);
        b = pick_corner(vcount_cfg, base);
        c = pick_corner(vcount_cfg, base);
        breaks_now = 1'b0;
        // rare out-of-range corner
        if (vcount_cfg < VCOUNT_RST && $urandom_range(0, 24) == 0) begin
          wild = VIDX_W'($urandom_range(int'(vcount_cfg), VERTS - 1));
          case ($urandom_range(0, 2))
            0:       a = wild;
            1:       b = wild;
            default: c = wild;
          endcase
          breaks_now = !drops_label(lbl);
        end
        send_face(lbl, a, b, c, f == mesh_len - 1);
        if (!broken) random_items++;
        broken = broken | breaks_now;
      end
    end

    // drain and let the pipeline go quiet
    send_idle_pct = 0;
    stall_pct     = 0;
    settle();

    $display("sent %0d triangles in %0d meshes, %0d result items compared",
             faces_sent, meshes_sent, results_seen);
    $display("covered label drops, repeated corners, index errors and all summary states");
    if (mismatch_count == 0 && results_left == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
